// File: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is high
`define SWM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define SWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/swm_pkg.sv
package swm_pkg;

  // defaults for the top level parameters
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // width of the window length register
  localparam int CFG_BITS = 7;

  // what one cell reports to its neighbours and to the control
  typedef struct packed {
    logic valid;
    logic kept;
    logic expired;
  } cell_stat_t;

  // broadcast command to every cell in the chain
  typedef struct packed {
    logic shift;
    logic insert;
    logic clear;
  } cell_ctl_t;

endpackage

// File: rtl/swm_cell.sv
module swm_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int POS_BITS    = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swm_pkg::cell_ctl_t            ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [POS_BITS-1:0]    sample_pos,
  input  logic        [POS_BITS-1:0]    age_ref,
  input  logic        [POS_BITS-1:0]    win,
  input  swm_pkg::cell_stat_t           right_stat,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic        [POS_BITS-1:0]    right_pos,
  input  logic                          left_kept_hold,
  input  logic                          left_kept_shift,
  output swm_pkg::cell_stat_t           stat,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [POS_BITS-1:0]    pos
);
  import swm_pkg::*;

  logic                          valid;
  logic        [POS_BITS-1:0]    age;
  logic                          kept;
  logic                          src_valid;
  logic                          src_kept;
  logic signed [SAMPLE_BITS-1:0] src_val;
  logic        [POS_BITS-1:0]    src_pos;
  logic                          left_kept;

  // age against the position of the next sample, wraps with the counter
  assign age = age_ref - pos;

  // candidate survives the new sample only if strictly greater
  assign kept = valid && !ctl.clear && (val > sample);

  assign stat.valid   = valid;
  assign stat.kept    = kept;
  assign stat.expired = valid && (age >= win);

  // source of this cell's next contents: itself or the neighbour towards the tail
  always_comb begin
    if (ctl.shift) begin
      src_valid = right_stat.valid;
      src_kept  = right_stat.kept;
      src_val   = right_val;
      src_pos   = right_pos;
      left_kept = left_kept_shift;
    end else begin
      src_valid = valid;
      src_kept  = kept;
      src_val   = val;
      src_pos   = pos;
      left_kept = left_kept_hold;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.insert) begin
      valid <= src_kept || left_kept;
    end else if (ctl.shift) begin
      valid <= src_valid;
    end
  end

  // candidate value and position; the first free cell after the kept run takes the sample
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (src_kept) begin
        val <= src_val;
        pos <= src_pos;
      end else begin
        val <= sample;
        pos <= sample_pos;
      end
    end else if (ctl.shift) begin
      val <= src_val;
      pos <= src_pos;
    end
  end

endmodule

// File: rtl/sliding_window_maximum.sv
// output: a result is registered and presented in the cycle after its sample's transaction
// throughput: one sample per cycle while the second candidate is still in the window
// and no result is stalled; after the window shrinks, each further stale candidate
// holds off a sample, as the cell chain drops only its head cell per cycle
// reset: synchronous, empties the cell chain, clears position and fill count, window 1
module sliding_window_maximum #(
  parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0]    window_size,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   sample,
  input  logic                            first,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   window_max,
  output logic                            final_window
);
  import swm_pkg::*;

  localparam int POS_BITS  = $clog2(WINDOW_MAX) + 1;
  localparam int FILL_BITS = $clog2(WINDOW_MAX + 1);
  localparam int CMP_BITS  = (POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS;

  logic        [CFG_BITS-1:0]    win_reg;
  logic        [CMP_BITS-1:0]    win_ext;
  logic        [POS_BITS-1:0]    eff_win;
  logic        [POS_BITS-1:0]    pos_cnt;
  logic        [POS_BITS-1:0]    sample_pos;
  logic        [FILL_BITS-1:0]   filled;
  logic        [FILL_BITS-1:0]   filled_next;
  logic                          drain;
  logic                          accept;
  logic                          emit;
  logic                          head_kept;
  logic signed [SAMPLE_BITS-1:0] head_val;
  logic signed [SAMPLE_BITS-1:0] head_next;
  cell_ctl_t                     ctl;

  cell_stat_t                    stat [0:WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] vals [0:WINDOW_MAX];
  logic        [POS_BITS-1:0]    poss [0:WINDOW_MAX];

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= CFG_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      win_reg <= window_size;
    end
  end

  // window length clamped to 1..WINDOW_MAX
  assign win_ext = CMP_BITS'(win_reg);

  always_comb begin
    priority if (win_reg == '0) begin
      eff_win = POS_BITS'(1);
    end else if (win_ext > CMP_BITS'(WINDOW_MAX)) begin
      eff_win = POS_BITS'(WINDOW_MAX);
    end else begin
      eff_win = POS_BITS'(win_ext);
    end
  end

  // stale head cells are dropped only ahead of a waiting sample of the same sequence
  assign drain = in_valid && !first && stat[1].expired;

  // handshake: hold off while a second stale candidate sits behind the head or a result is stalled
  assign in_ready = !drain && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // chain command
  assign ctl.insert = accept;
  assign ctl.clear  = accept && first;
  assign ctl.shift  = drain || (accept && !first && stat[0].expired);

  assign sample_pos = first ? '0 : pos_cnt;

  // sequence position and fill count
  always_comb begin
    if (first) begin
      filled_next = FILL_BITS'(1);
    end else if (filled == FILL_BITS'(WINDOW_MAX)) begin
      filled_next = filled;
    end else begin
      filled_next = filled + FILL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt <= '0;
      filled  <= '0;
    end else if (accept) begin
      pos_cnt <= sample_pos + POS_BITS'(1);
      filled  <= filled_next;
    end
  end

  assign emit = POS_BITS'(filled_next) >= eff_win;

  // value that lands in the head cell with this transaction
  assign head_kept = ctl.shift ? stat[1].kept : stat[0].kept;
  assign head_val  = ctl.shift ? vals[1] : vals[0];
  assign head_next = head_kept ? head_val : sample;

  // tail boundary of the chain
  assign stat[WINDOW_MAX] = '0;
  assign vals[WINDOW_MAX] = '0;
  assign poss[WINDOW_MAX] = '0;

  // the cell chain, head at index zero
  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic left_hold;
    logic left_shift;

    if (j == 0) begin : g_head
      assign left_hold  = 1'b1;
      assign left_shift = 1'b1;
    end else begin : g_body
      assign left_hold  = stat[j-1].kept;
      assign left_shift = stat[j].kept;
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_BITS    (POS_BITS)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl),
      .sample          (sample),
      .sample_pos      (sample_pos),
      .age_ref         (pos_cnt),
      .win             (eff_win),
      .right_stat      (stat[j+1]),
      .right_val       (vals[j+1]),
      .right_pos       (poss[j+1]),
      .left_kept_hold  (left_hold),
      .left_kept_shift (left_shift),
      .stat            (stat[j]),
      .val             (vals[j]),
      .pos             (poss[j])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      window_max   <= head_next;
      final_window <= last;
    end
  end

endmodule

// File: rtl/swm_checker.sv
`include "assert_macros.svh"

module swm_checker #(
  parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] window_max,
  input logic                   final_window
);
  import swm_pkg::*;

  // a pending result holds until its transaction
  `SWM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(window_max) && $stable(final_window), "result dropped or changed while stalled")

  // reset leaves no result pending
  `SWM_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid, "result pending after reset")

  // a result only follows an accepted sample
  `SWM_ASSERT(a_out_cause, clk, rst, $rose(out_valid) |-> $past(in_valid && in_ready), "result without a sample")

  // no sample taken while a stalled result blocks the output register
  `SWM_ASSERT(a_no_overrun, clk, rst, out_valid && !out_ready |-> !in_ready, "sample taken over a stalled result")

endmodule

bind sliding_window_maximum swm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .window_max   (window_max),
  .final_window (final_window)
);

// File: tb/sliding_window_maximum_test.sv
module sliding_window_maximum_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W    = swm_pkg::SAMPLE_BITS_DEF;
  localparam int DEPTH       = swm_pkg::WINDOW_MAX_DEF;
  localparam int CFG_W       = swm_pkg::CFG_BITS;
  localparam int POS_SPAN    = 2 * DEPTH;
  localparam int SETTLE_WAIT = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 20;

  typedef enum int {STYLE_SPREAD, STYLE_NARROW, STYLE_RAMP, STYLE_EXTREME} value_style_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       first_mark;
    logic                       last_mark;
  } sample_item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] peak;
    logic                       closing;
  } window_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           window_size = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       first = 1'b0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] window_max;
  logic                       final_window;

  sliding_window_maximum dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_size  (window_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .first        (first),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .window_max   (window_max),
    .final_window (final_window)
  );

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // stimulus and expectation stores
  sample_item_t   sample_backlog[$];
  window_result_t pending_maxima[$];
  int             items_queued = 0;
  int             items_taken = 0;
  int             mismatches = 0;
  int             quiet_cycles = 0;
  bit             steady = 1'b0;
  logic           in_taken = 1'b0;

  // predictor state: decreasing candidate queue
  logic signed [SAMPLE_W-1:0] peak_value [DEPTH];
  int                         peak_pos [DEPTH];
  int                         peak_head = 0;
  int                         peak_count = 0;
  int                         next_pos = 0;
  int                         seq_fill = 0;
  logic [CFG_W-1:0]           window_reg = 1;

  // window length as the block applies it
  function automatic int eff_window(logic [CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > DEPTH) return DEPTH;
    return int'(w);
  endfunction

  // take one sample into the candidate queue, queue the window maximum if due
  function automatic void predict_window_max(logic signed [SAMPLE_W-1:0] s, logic f, logic l);
    int w;
    int pos;
    int age;
    int idx;
    window_result_t r;
    w = eff_window(window_reg);
    if (f) begin
      peak_head = 0;
      peak_count = 0;
      next_pos = 0;
      seq_fill = 0;
    end
    pos = next_pos;
    // expire candidates at the front
    while (peak_count > 0) begin
      age = (pos + POS_SPAN - peak_pos[peak_head]) % POS_SPAN;
      if (age < w) break;
      peak_head = (peak_head + 1) % DEPTH;
      peak_count--;
    end
    // drop dominated candidates at the back
    while (peak_count > 0) begin
      idx = (peak_head + peak_count - 1) % DEPTH;
      if (peak_value[idx] > s) break;
      peak_count--;
    end
    if (peak_count >= DEPTH) begin
      peak_head = (peak_head + 1) % DEPTH;
      peak_count--;
    end
    idx = (peak_head + peak_count) % DEPTH;
    peak_value[idx] = s;
    peak_pos[idx] = pos;
    peak_count++;
    next_pos = (pos + 1) % POS_SPAN;
    if (seq_fill < DEPTH) seq_fill++;
    if (seq_fill >= w) begin
      r.peak = peak_value[peak_head];
      r.closing = l;
      pending_maxima.insert(pending_maxima.size(), r);
    end
  endfunction

  function automatic bit idle_now();
    return !steady && ($urandom_range(99) < 10);
  endfunction

  // sample driver
  always @(negedge clk) begin : drive_samples
    sample_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold until the transaction completes
    end else if (sample_backlog.size() > 0 && !idle_now()) begin
      next_item = sample_backlog[0];
      sample_backlog.delete(0);
      in_valid <= 1'b1;
      sample <= next_item.value;
      first <= next_item.first_mark;
      last <= next_item.last_mark;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    out_ready <= !idle_now();
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin : watch_ports
    window_result_t want;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) window_reg = window_size;
      if (in_valid && in_ready) begin
        predict_window_max(sample, first, last);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (pending_maxima.size() == 0) begin
          $display("%0t: unexpected result window_max %0d final_window %0b",
                   $time, window_max, final_window);
          mismatches++;
        end else begin
          want = pending_maxima[0];
          pending_maxima.delete(0);
          if (window_max !== want.peak) begin
            $display("%0t: window_max expected %0d actual %0d", $time, want.peak, window_max);
            mismatches++;
          end
          if (final_window !== want.closing) begin
            $display("%0t: final_window expected %0b actual %0b",
                     $time, want.closing, final_window);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** sliding_window_maximum: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(int value, bit f, bit l);
    sample_item_t it;
    it.value = SAMPLE_W'(value);
    it.first_mark = f;
    it.last_mark = l;
    sample_backlog.insert(sample_backlog.size(), it);
    items_queued++;
  endtask

  // wait for all samples and results to drain, then for the block to go quiet
  task automatic settle();
    while (items_taken != items_queued || pending_maxima.size() != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // called at a falling edge, returns at a rising edge
  task automatic write_window(int value);
    cfg_valid <= 1'b1;
    window_size <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_value(value_style_t st, int base, int step, int k);
    case (st)
      STYLE_NARROW: return int'($urandom_range(6)) - 3;
      STYLE_RAMP:   return base + k * step;
      STYLE_EXTREME: begin
        case ($urandom_range(4))
          0: return 32767;
          1: return -32768;
          2: return 0;
          3: return -1;
          default: return int'($urandom);
        endcase
      end
      default: return int'($urandom);
    endcase
  endfunction

  // one sequence: mostly long enough to give results, some short, some noise
  task automatic make_sequence(int eff, bit carry_on);
    int len;
    int roll;
    int base;
    int step;
    bit noise;
    bit f;
    bit l;
    value_style_t st;
    roll = $urandom_range(99);
    noise = 1'b0;
    if (roll < 75) begin
      len = $urandom_range(2 * eff + 10, eff);
    end else if (roll < 90) begin
      len = $urandom_range(eff, 1);
    end else begin
      len = $urandom_range(20, 1);
      noise = 1'b1;
    end
    st = value_style_t'($urandom_range(3));
    base = int'($urandom_range(65535)) - 32768;
    step = int'($urandom_range(400, 1)) * ($urandom_range(1) ? 1 : -1);
    for (int k = 0; k < len; k++) begin
      if (noise) begin
        f = ($urandom_range(9) == 0);
        l = ($urandom_range(3) == 0);
      end else begin
        f = (k == 0) && !carry_on;
        l = (k == len - 1);
      end
      push_item(pick_value(st, base, step, k), f, l);
    end
  endtask

  initial begin
    int phase_windows [8];
    int eff;
    int start;
    phase_windows = '{1, 0, 127, 64, 2, 5, 17, 40};
    phase_windows[6] = $urandom_range(63, 3);
    phase_windows[7] = $urandom_range(127, 0);

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of one, no first mark after reset, extremes, sample after a last mark
    push_item(100, 0, 0);
    push_item(32767, 1, 0);
    push_item(-32768, 0, 0);
    push_item(0, 0, 1);
    push_item(-1, 0, 0);
    push_item(7, 1, 1);

    // window of three: equal samples, short sequence, rising and falling runs
    settle();
    write_window(3);
    push_item(5, 1, 0);
    push_item(5, 0, 0);
    push_item(5, 0, 0);
    push_item(-32768, 0, 0);
    push_item(-32768, 0, 0);
    push_item(-32768, 0, 1);
    push_item(9, 1, 0);
    push_item(10, 0, 1);
    push_item(1, 1, 0);
    push_item(2, 0, 0);
    push_item(3, 0, 0);
    push_item(32767, 0, 0);
    push_item(2, 0, 0);
    push_item(1, 0, 1);

    // window grown mid-sequence
    settle();
    write_window(6);
    push_item(0, 0, 0);
    push_item(-5, 0, 1);

    // window shrunk mid-sequence with several stale candidates
    settle();
    write_window(8);
    push_item(100, 1, 0);
    push_item(90, 0, 0);
    push_item(80, 0, 0);
    push_item(70, 0, 0);
    push_item(60, 0, 0);
    settle();
    write_window(2);
    push_item(50, 0, 0);
    push_item(40, 0, 1);

    // random phases, one per window setting
    for (int p = 0; p < 8; p++) begin
      settle();
      write_window(phase_windows[p]);
      steady = (p == 3);
      eff = eff_window(CFG_W'(phase_windows[p]));
      start = items_queued;
      make_sequence(eff, $urandom_range(1) == 1);
      while (items_queued - start < PHASE_ITEMS) make_sequence(eff, 1'b0);
    end

    settle();
    if (mismatches == 0 && pending_maxima.size() == 0) begin
      $display("** sliding_window_maximum: PASSED **");
    end else begin
      $display("** sliding_window_maximum: FAILED **");
    end
    $finish;
  end

endmodule
